// ===== hdl/rlecpe_pkg.sv =====
package rlecpe_pkg;

  // Length fields cover the largest packet (128 bytes)
  localparam int LEN_W          = 8;
  localparam int MAX_PACKET_DEF = 128;
  // Bytes per output chunk
  localparam int CHUNK_BYTES    = 4;

  // Packet builder mode; code 3 falls into the idle arm
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_LIT  = 2'd2
  } mode_t;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_SEND = 2'd2
  } bk_state_t;

  // One settled packet, queued between front and back
  typedef struct packed {
    logic             is_lit;
    logic             seg_last;
    logic [LEN_W-1:0] len;
    logic [7:0]       value;
  } pkt_cmd_t;

  // Literal store write; pair writes positions 1 and 2 at once
  typedef struct packed {
    logic             en;
    logic             pair;
    logic [LEN_W-1:0] pos;
    logic [7:0]       b0;
    logic [7:0]       b1;
  } lit_wr_t;

  // Back end status seen by the front
  typedef struct packed {
    logic lit_active;
    logic lit_done;
  } bk_stat_t;

endpackage

// ===== hdl/rlecpe_ifs.sv =====
// Raw byte channel
interface rlecpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Encoded chunk channel
interface rlecpe_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_bytes;
  logic [2:0]  out_count;
  logic        out_last;

  modport source (output valid, output out_bytes, output out_count, output out_last,
                  input ready);
  modport sink   (input valid, input out_bytes, input out_count, input out_last,
                  output ready);
endinterface

// ===== hdl/rlecpe_front.sv =====
module rlecpe_front
  import rlecpe_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  rlecpe_in_if.sink      in_chan,
  input  logic           cq_room2,
  input  bk_stat_t       bk_stat,
  output logic           cq_push0,
  output logic           cq_push1,
  output pkt_cmd_t       cq_d0,
  output pkt_cmd_t       cq_d1,
  output lit_wr_t        lit_wr
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PACKET);
  localparam logic [LEN_W-1:0] TRIPLE  = LEN_W'(3);

  function automatic pkt_cmd_t mk_cmd(input logic is_lit, input logic [LEN_W-1:0] len,
                                      input logic [7:0] value);
    pkt_cmd_t c;
    c.is_lit   = is_lit;
    c.seg_last = 1'b0;
    c.len      = len;
    c.value    = value;
    return c;
  endfunction

  mode_t            mode_r, mode_nxt;
  logic [7:0]       run_val_r, run_val_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic [LEN_W-1:0] lit_len_r, lit_len_nxt;
  logic [7:0]       prev1_r, prev1_nxt;   // last literal byte
  logic [7:0]       prev2_r, prev2_nxt;   // one before it
  logic [7:0]       held_r, held_nxt;
  logic             held_vld_r, held_vld_nxt;
  logic             lit_busy_r, lit_busy_nxt;

  logic             in_acc;
  logic             triple;
  logic             lit_pushed;
  logic [1:0]       n_cmd;
  pkt_cmd_t         cmd [2];
  lit_wr_t          wr;

  // Stall while a literal is read out of the store or the queue is short
  assign in_chan.ready = !lit_busy_r && cq_room2;
  assign in_acc        = in_chan.valid && in_chan.ready;

  // Two equal literal bytes followed by a third
  assign triple = (lit_len_r >= LEN_W'(2)) && (prev2_r == in_chan.in_byte) &&
                  (prev1_r == in_chan.in_byte);

  // Packet classification, one byte per transfer
  always_comb begin
    mode_nxt     = mode_r;
    run_val_nxt  = run_val_r;
    run_len_nxt  = run_len_r;
    lit_len_nxt  = lit_len_r;
    prev1_nxt    = prev1_r;
    prev2_nxt    = prev2_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    n_cmd        = '0;
    cmd[0]       = '0;
    cmd[1]       = '0;
    wr           = '0;

    if (in_acc) begin
      unique case (mode_r)
        MODE_RUN: begin
          if (in_chan.in_byte == run_val_r) begin
            run_len_nxt = run_len_r + 1'b1;
            if (run_len_nxt >= MAX_LEN) begin
              cmd[n_cmd[0]] = mk_cmd(1'b0, run_len_nxt, run_val_r);
              n_cmd         = n_cmd + 2'd1;
              mode_nxt      = MODE_IDLE;
              run_len_nxt   = '0;
            end
          end else begin
            cmd[n_cmd[0]] = mk_cmd(1'b0, run_len_r, run_val_r);
            n_cmd         = n_cmd + 2'd1;
            mode_nxt      = MODE_IDLE;
            run_len_nxt   = '0;
            held_nxt      = in_chan.in_byte;
            held_vld_nxt  = 1'b1;
          end
        end
        MODE_LIT: begin
          if (triple) begin
            // literal ends before the two bytes that open the run
            if (lit_len_r != LEN_W'(2)) begin
              cmd[n_cmd[0]] = mk_cmd(1'b1, lit_len_r - LEN_W'(2), 8'h00);
              n_cmd         = n_cmd + 2'd1;
            end
            lit_len_nxt = '0;
            mode_nxt    = MODE_RUN;
            run_val_nxt = in_chan.in_byte;
            run_len_nxt = TRIPLE;
            if (TRIPLE >= MAX_LEN) begin
              cmd[n_cmd[0]] = mk_cmd(1'b0, TRIPLE, in_chan.in_byte);
              n_cmd         = n_cmd + 2'd1;
              mode_nxt      = MODE_IDLE;
              run_len_nxt   = '0;
            end
          end else begin
            wr.en       = 1'b1;
            wr.pos      = lit_len_r + 1'b1;
            wr.b0       = in_chan.in_byte;
            prev2_nxt   = prev1_r;
            prev1_nxt   = in_chan.in_byte;
            lit_len_nxt = lit_len_r + 1'b1;
            if (lit_len_nxt >= MAX_LEN) begin
              cmd[n_cmd[0]] = mk_cmd(1'b1, lit_len_nxt, 8'h00);
              n_cmd         = n_cmd + 2'd1;
              lit_len_nxt   = '0;
              mode_nxt      = MODE_IDLE;
            end
          end
        end
        default: begin
          mode_nxt = MODE_IDLE;
          if (!held_vld_r) begin
            held_nxt     = in_chan.in_byte;
            held_vld_nxt = 1'b1;
          end else if (in_chan.in_byte == held_r) begin
            held_vld_nxt = 1'b0;
            mode_nxt     = MODE_RUN;
            run_val_nxt  = in_chan.in_byte;
            run_len_nxt  = LEN_W'(2);
          end else begin
            held_vld_nxt = 1'b0;
            mode_nxt     = MODE_LIT;
            wr.en        = 1'b1;
            wr.pair      = 1'b1;
            wr.b0        = held_r;
            wr.b1        = in_chan.in_byte;
            prev2_nxt    = held_r;
            prev1_nxt    = in_chan.in_byte;
            lit_len_nxt  = LEN_W'(2);
          end
        end
      endcase

      // Segment end: flush whatever is pending, then back to reset state
      if (in_chan.in_last) begin
        unique case (mode_nxt)
          MODE_RUN: begin
            cmd[n_cmd[0]] = mk_cmd(1'b0, run_len_nxt, run_val_nxt);
            n_cmd         = n_cmd + 2'd1;
          end
          MODE_LIT: begin
            cmd[n_cmd[0]] = mk_cmd(1'b1, lit_len_nxt, 8'h00);
            n_cmd         = n_cmd + 2'd1;
          end
          default: begin
            if (held_vld_nxt) begin
              wr.en         = 1'b1;
              wr.pair       = 1'b0;
              wr.pos        = LEN_W'(1);
              wr.b0         = held_nxt;
              cmd[n_cmd[0]] = mk_cmd(1'b1, LEN_W'(1), 8'h00);
              n_cmd         = n_cmd + 2'd1;
            end
          end
        endcase
        if (n_cmd != 2'd0) begin
          cmd[n_cmd[1]].seg_last = 1'b1;
        end
        mode_nxt     = MODE_IDLE;
        run_val_nxt  = '0;
        run_len_nxt  = '0;
        lit_len_nxt  = '0;
        held_nxt     = '0;
        held_vld_nxt = 1'b0;
      end
    end
  end

  // Queue pushes and store write
  assign cq_push0   = in_acc && (n_cmd != 2'd0);
  assign cq_push1   = in_acc && (n_cmd == 2'd2);
  assign cq_d0      = cmd[0];
  assign cq_d1      = cmd[1];
  assign lit_wr     = wr;
  assign lit_pushed = (cq_push0 && cmd[0].is_lit) || (cq_push1 && cmd[1].is_lit);

  // Store owned by the back end from literal push until its last chunk is read
  always_comb begin
    lit_busy_nxt = lit_busy_r;
    if (lit_pushed) begin
      lit_busy_nxt = 1'b1;
    end else if (bk_stat.lit_done) begin
      lit_busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      run_len_r  <= '0;
      lit_len_r  <= '0;
      held_vld_r <= 1'b0;
      lit_busy_r <= 1'b0;
      run_val_r  <= '0;
      held_r     <= '0;
    end else begin
      mode_r     <= mode_nxt;
      run_len_r  <= run_len_nxt;
      lit_len_r  <= lit_len_nxt;
      held_vld_r <= held_vld_nxt;
      lit_busy_r <= lit_busy_nxt;
      run_val_r  <= run_val_nxt;
      held_r     <= held_nxt;
    end
  end

  // Literal tail bytes need no reset
  always_ff @(posedge clk) begin
    prev1_r <= prev1_nxt;
    prev2_r <= prev2_nxt;
  end

endmodule

// ===== hdl/rlecpe_cq.sv =====
module rlecpe_cq
  import rlecpe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push0,
  input  logic     push1,
  input  pkt_cmd_t d0,
  input  pkt_cmd_t d1,
  input  logic     pop,
  output pkt_cmd_t q,
  output logic     empty,
  output logic     room2
);

  localparam int CQ_DEPTH = 4;
  localparam int PTR_W    = $clog2(CQ_DEPTH);
  localparam int CNT_W    = PTR_W + 1;

  pkt_cmd_t           ent_r [CQ_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PTR_W-1:0]   wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign q         = ent_r[rd_ptr_r];
  assign empty     = (cnt_r == '0);
  assign room2     = (cnt_r <= CNT_W'(CQ_DEPTH - 2));

  // Pointer and fill tracking; up to two pushes and one pop per cycle
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push0) + PTR_W'(push1);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    cnt_nxt    = cnt_r + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push0) begin
      ent_r[wr_ptr_r] <= d0;
    end
    if (push1) begin
      ent_r[wr_ptr_p1] <= d1;
    end
  end

endmodule

// ===== hdl/rlecpe_back.sv =====
module rlecpe_back
  import rlecpe_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  lit_wr_t       lit_wr,
  input  pkt_cmd_t      cq_q,
  input  logic          cq_empty,
  output logic          cq_pop,
  output bk_stat_t      bk_stat,
  rlecpe_out_if.source  out_chan
);

  // Store word w holds packet bytes 4w..4w+3; packet byte 0 is the header
  localparam int WORDS = (MAX_PACKET + CHUNK_BYTES) / CHUNK_BYTES;
  localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int TOT_W = LEN_W + 1;

  logic [3:0][7:0]  lit_mem [WORDS];
  logic [3:0][7:0]  rd_word_r;
  logic [WAW-1:0]   wr_addr;

  bk_state_t        st_r, st_nxt;
  pkt_cmd_t         cmd_r, cmd_nxt;
  logic [WAW-1:0]   idx_r, idx_nxt;

  logic             out_vld_r, out_vld_nxt;
  logic [31:0]      out_bytes_r, out_bytes_nxt;
  logic [2:0]       out_count_r, out_count_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  logic [7:0]       header;
  logic [TOT_W-1:0] rem;
  logic             final_chunk;
  logic [2:0]       chunk_cnt;
  logic [3:0][7:0]  chunk;
  logic             lit_done;

  assign wr_addr = lit_wr.pair ? '0 : lit_wr.pos[WAW+1:2];

  // Literal store: byte-lane writes from the front, registered word read
  always_ff @(posedge clk) begin
    if (lit_wr.en) begin
      if (lit_wr.pair) begin
        lit_mem[0][1] <= lit_wr.b0;
        lit_mem[0][2] <= lit_wr.b1;
      end else begin
        lit_mem[wr_addr][lit_wr.pos[1:0]] <= lit_wr.b0;
      end
    end
    if (st_r == BK_READ) begin
      rd_word_r <= lit_mem[idx_r];
    end
  end

  // Header: run flag on top, length minus one below
  always_comb begin
    header      = 8'h00;
    header[7]   = !cmd_r.is_lit;
    header[6:0] = 7'((cmd_r.len - 1'b1) & LEN_W'(8'h7f));
  end

  // Chunk assembly
  always_comb begin
    rem         = (TOT_W'(cmd_r.len) + 1'b1) - TOT_W'({idx_r, 2'b00});
    final_chunk = 1'b1;
    chunk_cnt   = 3'd2;
    chunk       = '0;
    if (cmd_r.is_lit) begin
      final_chunk = (rem <= TOT_W'(CHUNK_BYTES));
      chunk_cnt   = final_chunk ? rem[2:0] : 3'(CHUNK_BYTES);
      chunk       = rd_word_r;
      if (idx_r == '0) begin
        chunk[0] = header;
      end
      for (int i = 0; i < CHUNK_BYTES; i++) begin
        if (3'(i) >= chunk_cnt) begin
          chunk[i] = 8'h00;
        end
      end
    end else begin
      chunk[0] = header;
      chunk[1] = cmd_r.value;
    end
  end

  assign slot_free = !out_vld_r || out_chan.ready;

  // Sequencer: pop, read one store word, send one chunk
  always_comb begin
    st_nxt        = st_r;
    cmd_nxt       = cmd_r;
    idx_nxt       = idx_r;
    cq_pop        = 1'b0;
    lit_done      = 1'b0;
    out_vld_nxt   = out_vld_r && !out_chan.ready;
    out_bytes_nxt = out_bytes_r;
    out_count_nxt = out_count_r;
    out_last_nxt  = out_last_r;

    unique case (st_r)
      BK_IDLE: begin
        if (!cq_empty) begin
          cq_pop  = 1'b1;
          cmd_nxt = cq_q;
          idx_nxt = '0;
          st_nxt  = BK_READ;
        end
      end
      BK_READ: begin
        st_nxt = BK_SEND;
      end
      BK_SEND: begin
        if (slot_free) begin
          out_vld_nxt   = 1'b1;
          out_bytes_nxt = chunk;
          out_count_nxt = chunk_cnt;
          out_last_nxt  = cmd_r.seg_last && final_chunk;
          if (final_chunk) begin
            lit_done = cmd_r.is_lit;
            st_nxt   = BK_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = BK_READ;
          end
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  assign bk_stat.lit_done   = lit_done;
  assign bk_stat.lit_active = (st_r != BK_IDLE) && cmd_r.is_lit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= BK_IDLE;
      out_vld_r <= 1'b0;
      cmd_r     <= '0;
      idx_r     <= '0;
    end else begin
      st_r      <= st_nxt;
      out_vld_r <= out_vld_nxt;
      cmd_r     <= cmd_nxt;
      idx_r     <= idx_nxt;
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    out_bytes_r <= out_bytes_nxt;
    out_count_r <= out_count_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.out_bytes = out_bytes_r;
  assign out_chan.out_count = out_count_r;
  assign out_chan.out_last  = out_last_r;

endmodule

// ===== hdl/rle_channel_packet_encoder_unit.sv =====
// Channel   Dir  Payload                                   Transfer
// in_chan   in   in_byte[7:0], in_last                     valid && ready
// out_chan  out  out_bytes[31:0], out_count[2:0], out_last valid && ready
//
// A byte is classified in the cycle it transfers; settled packets enter a
// four-entry command queue. The back end pops a packet, then for each
// output chunk reads a store word and then sends the chunk. Input stalls
// while a literal is read out of the store or the queue has fewer than two
// free entries. Synchronous active-low reset clears control state; the
// literal store is not cleared. A stalled output holds its chunk.
module rle_channel_packet_encoder_unit
  import rlecpe_pkg::*;
#(
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  rlecpe_in_if.sink    in_chan,
  rlecpe_out_if.source out_chan
);

  logic     cq_push0;
  logic     cq_push1;
  pkt_cmd_t cq_d0;
  pkt_cmd_t cq_d1;
  logic     cq_pop;
  pkt_cmd_t cq_q;
  logic     cq_empty;
  logic     cq_room2;
  lit_wr_t  lit_wr;
  bk_stat_t bk_stat;

  // Front end: packet classification
  rlecpe_front #(
    .MAX_PACKET (MAX_PACKET)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .cq_room2 (cq_room2),
    .bk_stat  (bk_stat),
    .cq_push0 (cq_push0),
    .cq_push1 (cq_push1),
    .cq_d0    (cq_d0),
    .cq_d1    (cq_d1),
    .lit_wr   (lit_wr)
  );

  // Packet command queue
  rlecpe_cq u_cq (
    .clk   (clk),
    .rst_n (rst_n),
    .push0 (cq_push0),
    .push1 (cq_push1),
    .d0    (cq_d0),
    .d1    (cq_d1),
    .pop   (cq_pop),
    .q     (cq_q),
    .empty (cq_empty),
    .room2 (cq_room2)
  );

  // Back end: chunk emission
  rlecpe_back #(
    .MAX_PACKET (MAX_PACKET)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .lit_wr   (lit_wr),
    .cq_q     (cq_q),
    .cq_empty (cq_empty),
    .cq_pop   (cq_pop),
    .bk_stat  (bk_stat),
    .out_chan (out_chan)
  );

`ifndef ASSERT_OFF
  // Front must not write the store while a literal is being read out
  a_store_owned: assert property (@(posedge clk) disable iff (!rst_n)
    lit_wr.en |-> !bk_stat.lit_active)
    else $error("literal store written during readout");

  // Queue pop only with an entry present
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cq_pop |-> !cq_empty)
    else $error("command queue underflow");

  // Second push only alongside the first
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    cq_push1 |-> cq_push0)
    else $error("second queue push without first");

  // Chunk byte count stays within one to four
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.out_count != 3'd0) && (out_chan.out_count <= 3'd4))
    else $error("chunk byte count out of range");
`endif

endmodule
